// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stack machine executor
// Instruction codes, status codes, controller states and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sme_pkg;
	localparam int DefStackDepth = 64;
	localparam int DataW = 32;

	typedef enum logic [3:0] {
		ACT_PUSH_IMM = 4'd0,
		ACT_PUSH_REG = 4'd1,
		ACT_POP_REG  = 4'd2,
		ACT_DIV      = 4'd3,
		ACT_SUB      = 4'd4,
		ACT_IN       = 4'd5,
		ACT_MUL      = 4'd6,
		ACT_OUT      = 4'd7,
		ACT_HLT      = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_IGNORED = 3'd4,
		ST_SAT     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_EXEC,
		S_DIV,
		S_WB,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_top;
		logic rd_next;
		logic exec;
		logic div_start;
		logic wb;
		logic resp_set;
	} cmd_t;

	typedef struct packed {
		logic two_op;
		logic is_div;
		logic div_busy;
	} stat_t;
endpackage

// ===== rtl/stack_machine_executor_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor_core: decoded stack-machine instruction executor
// Executes one instruction per request on a Q16.16 operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_ready carry action, immediate, reg_index and
//   in_value. Every request yields exactly one response on out_rvalid /
//   out_rready with out_valid, out_value, halted and status.
//   Sequence: after the request is taken, pushes, pops, out, hlt and rejected
//   requests pass through stack read, execute, write back and response load;
//   sub, mul and a divide by zero add a second stack read, and div adds that
//   read and a divide step whose radix-2 divider retires one of 48 quotient
//   bits per cycle and holds the sequencer until the last bit is done.
//   Flow: one request in flight; the next is taken the cycle after the
//   response has been loaded, so a request can be accepted while the previous
//   response still waits.
//   Reset clears stack depth, general registers and the halt flag; the stack
//   memory is not cleared. A stalled receiver holds the response and the
//   block waits with in_ready low until the response register frees up.
// ----------------------------------------------------------------------------
module stack_machine_executor_core import sme_pkg::*; #(
	parameter int STACK_DEPTH = DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  action,
	input  logic [15:0] immediate,
	input  logic [1:0]  reg_index,
	input  logic [31:0] in_value,
	output logic        out_rvalid,
	input  logic        out_rready,
	output logic        out_valid,
	output logic [31:0] out_value,
	output logic        halted,
	output logic [2:0]  status
);
	cmd_t cmd;
	stat_t stat;
	logic idle, rvld, fire;

	assign in_ready = idle;
	assign fire = in_valid && in_ready;
	assign out_rvalid = rvld;

	sme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire),
		.resp_free(!rvld || out_rready), .stat(stat), .cmd(cmd), .idle(idle)
	);

	sme_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .immediate(immediate), .reg_index(reg_index),
		.in_value(in_value), .resp_take(out_rready), .resp_vld(rvld),
		.out_valid(out_valid), .out_value(out_value), .halted(halted),
		.status(status)
	);
endmodule

// ===== rtl/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// sme_ctrl: instruction sequencer
// Steps each request through stack reads, execute, divide, write back and response.
// ----------------------------------------------------------------------------
module sme_ctrl import sme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  resp_free,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  idle
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_RD1;
			S_RD1: state_d = stat.two_op ? S_RD2 : S_EXEC;
			S_RD2: state_d = S_EXEC;
			S_EXEC: state_d = stat.is_div ? S_DIV : S_WB;
			S_DIV: if (!stat.div_busy) state_d = S_WB;
			S_WB: state_d = S_RESP;
			S_RESP: if (resp_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				cmd.load = in_fire;
			end
			S_RD1: cmd.rd_top = 1'b1;
			S_RD2: cmd.rd_next = 1'b1;
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.div_start = stat.is_div;
			end
			S_DIV: ;
			S_WB: cmd.wb = 1'b1;
			S_RESP: cmd.resp_set = resp_free;
			default: ;
		endcase
	end
endmodule

// ===== rtl/sme_div.sv =====
// ----------------------------------------------------------------------------
// sme_div: radix-2 signed Q16.16 divider
// Restoring division of |next|<<16 by |top|, one quotient bit per cycle,
// then sign fixup and saturation.
// ----------------------------------------------------------------------------
module sme_div import sme_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] num,
	input  logic [DataW-1:0] den,
	output logic             busy,
	output logic [DataW-1:0] quo,
	output logic             sat
);
	localparam int NW = DataW + 16;
	logic [NW-1:0] dvd_q;
	logic [DataW:0] rem_q;
	logic [DataW-1:0] den_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [DataW:0] trial;

	assign trial = {rem_q[DataW-1:0], dvd_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[DataW-1] ? -num : num), 16'd0};
			den_q <= den[DataW-1] ? -den : den;
			rem_q <= '0;
			neg_q <= num[DataW-1] ^ den[DataW-1];
		end else if (busy_q) begin
			if (!trial[DataW]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW-1:0], dvd_q[NW-1]};
				dvd_q <= {dvd_q[NW-2:0], 1'b0};
			end
		end
	end

	logic big;
	always_comb begin
		big = 1'b0;
		quo = '0;
		if (neg_q) begin
			big = dvd_q > NW'(33'h080000000);
			quo = big ? 32'h80000000 : -dvd_q[DataW-1:0];
		end else begin
			big = dvd_q > NW'(32'h7fffffff);
			quo = big ? 32'h7fffffff : dvd_q[DataW-1:0];
		end
	end
	assign sat = big;
	assign busy = busy_q;
endmodule

// ===== rtl/sme_dp.sv =====
// ----------------------------------------------------------------------------
// sme_dp: stack machine datapath
// Operand stack memory, stack depth, general registers, halt flag, ALU and
// the response register.
// ----------------------------------------------------------------------------
module sme_dp import sme_pkg::*; #(
	parameter int STACK_DEPTH = DefStackDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [3:0]       action,
	input  logic [15:0]      immediate,
	input  logic [1:0]       reg_index,
	input  logic [31:0]      in_value,
	input  logic             resp_take,
	output logic             resp_vld,
	output logic             out_valid,
	output logic [31:0]      out_value,
	output logic             halted,
	output logic [2:0]       status
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [DataW-1:0] mem [STACK_DEPTH];
	logic [CW-1:0] depth_q;
	logic [DataW-1:0] gr_q [4];
	logic halt_q;
	logic [3:0] act_q;
	logic [15:0] imm_q;
	logic [1:0] ri_q;
	logic [31:0] inv_q;
	logic [DataW-1:0] rd_q, top_q, res_q;
	logic [2:0] st_q;
	logic wr_q, ovld_q;
	logic [DataW-1:0] oval_q;
	logic rvld_q;
	logic [CW-1:0] ndep_q;
	logic [AW-1:0] rd_addr;
	logic div_busy, div_sat;
	logic [DataW-1:0] div_quo;
	logic [63:0] prod;
	logic [63:0] pshift;
	logic [32:0] diff;
	logic is_arith;

	assign is_arith = act_q == ACT_DIV || act_q == ACT_SUB || act_q == ACT_MUL;
	assign stat.two_op = is_arith && !halt_q && depth_q >= CW'(2);
	assign stat.is_div = stat.two_op && act_q == ACT_DIV && top_q != '0 && st_q == ST_OK;
	assign stat.div_busy = div_busy;

	assign rd_addr = cmd.rd_next ? AW'(depth_q - CW'(2)) : AW'(depth_q - CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.rd_top || cmd.rd_next) rd_q <= mem[rd_addr];
	end

	sme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(rd_q), .den(top_q), .busy(div_busy), .quo(div_quo), .sat(div_sat)
	);

	assign prod = $signed(rd_q) * $signed(top_q);
	assign pshift = $signed(prod + (prod[63] ? 64'hffff : 64'd0)) >>> 16;
	assign diff = {rd_q[31], rd_q} - {top_q[31], top_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			imm_q <= immediate;
			ri_q <= reg_index;
			inv_q <= in_value;
		end
		if (cmd.rd_top) top_q <= rd_q;
		if (cmd.rd_next) top_q <= rd_q;
	end

	// decode and execute: set result, write enable, new depth, status and halt; write back depth; response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			halt_q <= 1'b0;
			for (int i = 0; i < 4; i++) gr_q[i] <= '0;
			rvld_q <= 1'b0;
			st_q <= ST_OK;
			wr_q <= 1'b0;
			ovld_q <= 1'b0;
			oval_q <= '0;
			ndep_q <= '0;
			res_q <= '0;
		end else begin
			if (cmd.load) st_q <= ST_OK;
			if (cmd.rd_top) begin
				// rd_q holds top read address result next cycle; decide here
				wr_q <= 1'b0;
				ovld_q <= 1'b0;
				oval_q <= '0;
				ndep_q <= depth_q;
				if (halt_q) begin
					st_q <= ST_IGNORED;
				end else begin
					case (act_q) inside
						ACT_PUSH_IMM, ACT_PUSH_REG, ACT_IN: begin
							if (depth_q >= CW'(STACK_DEPTH)) st_q <= ST_OVER;
							else begin
								wr_q <= 1'b1;
								ndep_q <= depth_q + CW'(1);
								res_q <= (act_q == ACT_PUSH_IMM) ? {imm_q, 16'd0} :
									(act_q == ACT_IN) ? inv_q : gr_q[ri_q];
							end
						end
						ACT_POP_REG, ACT_OUT: begin
							if (depth_q == '0) st_q <= ST_UNDER;
							else ndep_q <= depth_q - CW'(1);
						end
						ACT_DIV, ACT_SUB, ACT_MUL: begin
							if (depth_q < CW'(2)) st_q <= ST_UNDER;
							else ndep_q <= depth_q - CW'(1);
						end
						ACT_HLT: halt_q <= 1'b1;
						default: ;
					endcase
				end
			end
			if (cmd.exec && !halt_q && st_q == ST_OK) begin
				if (act_q == ACT_POP_REG && depth_q != '0) gr_q[ri_q] <= rd_q;
				if (act_q == ACT_OUT && depth_q != '0) begin
					ovld_q <= 1'b1;
					oval_q <= rd_q;
				end
				if (stat.two_op) begin
					if (act_q == ACT_DIV && top_q == '0) begin
						st_q <= ST_DIVZ;
						ndep_q <= depth_q - CW'(2);
					end else if (act_q == ACT_SUB) begin
						wr_q <= 1'b1;
						if (diff[32] != diff[31]) begin
							st_q <= ST_SAT;
							res_q <= diff[32] ? 32'h80000000 : 32'h7fffffff;
						end else res_q <= diff[31:0];
					end else if (act_q == ACT_MUL) begin
						wr_q <= 1'b1;
						if (pshift[63:31] != {33{pshift[63]}}) begin
							st_q <= ST_SAT;
							res_q <= pshift[63] ? 32'h80000000 : 32'h7fffffff;
						end else res_q <= pshift[31:0];
					end
				end
			end
			if (cmd.wb) begin
				depth_q <= ndep_q;
			end
			if (div_busy == 1'b0 && act_q == ACT_DIV && cmd.wb && st_q == ST_OK
				&& !halt_q && depth_q >= CW'(2)) begin
				if (div_sat) st_q <= ST_SAT;
			end
			if (cmd.resp_set) rvld_q <= 1'b1;
			else if (resp_take) rvld_q <= 1'b0;
		end
	end

	// divide result feeds the write data on the write-back cycle
	logic [DataW-1:0] wdat;
	logic wen;
	assign wen = (act_q == ACT_DIV && cmd.wb && !halt_q && depth_q >= CW'(2)
		&& st_q == ST_OK) || (wr_q && cmd.wb && act_q != ACT_DIV);
	assign wdat = (act_q == ACT_DIV) ? div_quo : res_q;

	always_ff @(posedge clk) begin
		if (wen) mem[AW'(ndep_q - CW'(1))] <= wdat;
	end

	logic [31:0] oval_s1;
	logic ovld_s1, halt_s1;
	logic [2:0] st_s1;
	always_ff @(posedge clk) begin
		if (cmd.resp_set) begin
			oval_s1 <= oval_q;
			ovld_s1 <= ovld_q;
			halt_s1 <= halt_q;
			st_s1 <= st_q;
		end
	end

	assign resp_vld = rvld_q;
	assign out_valid = ovld_s1;
	assign out_value = oval_s1;
	assign halted = halt_s1;
	assign status = st_s1;
endmodule

// ===== rtl/sme_chk.sv =====
// ----------------------------------------------------------------------------
// sme_chk: port checker
// Watches the request and response channels and the halted flag.
// ----------------------------------------------------------------------------
module sme_chk import sme_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_rvalid,
	input logic       out_rready,
	input logic       out_valid,
	input logic       halted,
	input logic [2:0] status
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request dropped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_rvalid && !out_rready |=> out_rvalid && $stable(status))
		else $error("response dropped");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_rvalid && halted |-> status == ST_OK || status == ST_IGNORED)
		else $error("bad halted status");
	a_ovld: assert property (@(posedge clk) disable iff (!arst_n)
		out_rvalid && out_valid |-> status == ST_OK)
		else $error("out with error");
endmodule

bind stack_machine_executor_core sme_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_rvalid(out_rvalid), .out_rready(out_rready), .out_valid(out_valid),
	.halted(halted), .status(status)
);

// ===== test/stack_machine_executor_core_tb.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor_core_tb: self-checking bench of the stack executor
// Drives decoded instructions over valid/ready, predicts every response from
// a behavioral copy of the stack, registers and halt flag, and compares each
// response field by field; both sides idle at random until the last phase.
// ----------------------------------------------------------------------------
module stack_machine_executor_core_tb;
	import sme_pkg::*;

	localparam int Depth = DefStackDepth;
	localparam int Limit = 2000000;

	typedef struct packed {
		logic [3:0]  act;
		logic [15:0] imm;
		logic [1:0]  ri;
		logic [31:0] inv;
	} instr_t;

	typedef struct packed {
		logic        vld;
		logic [31:0] val;
		logic        hlt;
		logic [2:0]  st;
	} resp_t;

	typedef struct {
		instr_t ins;
		logic   known;
		resp_t  rsp;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [3:0]  action = '0;
	logic [15:0] immediate = '0;
	logic [1:0]  reg_index = '0;
	logic [31:0] in_value = '0;
	logic        out_rvalid;
	logic        out_rready = 0;
	logic        out_valid;
	logic [31:0] out_value;
	logic        halted;
	logic [2:0]  status;

	stack_machine_executor_core DUT (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	logic signed [31:0] mdl_stack [Depth];
	int                 mdl_depth;
	logic signed [31:0] mdl_regs [4];
	logic               mdl_halt;

	resp_t expected_resp [$];
	int    mismatches = 0;
	int    cycles = 0;
	int    send_idle = 14;
	int    recv_idle = 69;
	int    hold_off = 0;
	int    n_out = 0;
	int    n_sat = 0;
	int    n_divz = 0;

	function automatic logic [31:0] clamp32(longint v, ref logic [2:0] st);
		if (v > 64'sd2147483647) begin
			st = ST_SAT;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			st = ST_SAT;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic resp_t execute_instr(instr_t x);
		resp_t      r;
		longint     t, n, q;
		logic [2:0] cst;
		r = '0;
		r.st = ST_OK;
		cst = ST_OK;
		if (mdl_halt) begin
			r.st = ST_IGNORED;
		end else begin
			case (x.act) inside
				ACT_PUSH_IMM, ACT_PUSH_REG, ACT_IN: begin
					if (mdl_depth >= Depth) begin
						r.st = ST_OVER;
					end else begin
						if (x.act == ACT_PUSH_IMM)
							mdl_stack[mdl_depth] = {x.imm, 16'h0};
						else if (x.act == ACT_PUSH_REG)
							mdl_stack[mdl_depth] = mdl_regs[x.ri];
						else
							mdl_stack[mdl_depth] = x.inv;
						mdl_depth++;
					end
				end
				ACT_POP_REG, ACT_OUT: begin
					if (mdl_depth == 0) begin
						r.st = ST_UNDER;
					end else begin
						mdl_depth--;
						if (x.act == ACT_OUT) begin
							r.vld = 1;
							r.val = mdl_stack[mdl_depth];
						end else begin
							mdl_regs[x.ri] = mdl_stack[mdl_depth];
						end
					end
				end
				ACT_DIV, ACT_SUB, ACT_MUL: begin
					if (mdl_depth < 2) begin
						r.st = ST_UNDER;
					end else begin
						t = mdl_stack[mdl_depth-1];
						n = mdl_stack[mdl_depth-2];
						mdl_depth -= 2;
						if (x.act == ACT_DIV && t == 0) begin
							r.st = ST_DIVZ;
						end else begin
							if (x.act == ACT_DIV)
								q = (n * 65536) / t;
							else if (x.act == ACT_SUB)
								q = n - t;
							else
								q = (n * t) / 65536;
							mdl_stack[mdl_depth] = clamp32(q, cst);
							r.st = cst;
							mdl_depth++;
						end
					end
				end
				ACT_HLT: mdl_halt = 1;
				default: ;
			endcase
		end
		r.hlt = mdl_halt;
		return r;
	endfunction

	function automatic instr_t mk(logic [3:0] a, logic [15:0] i, logic [1:0] g,
		logic [31:0] v);
		instr_t x;
		x.act = a;
		x.imm = i;
		x.ri = g;
		x.inv = v;
		return x;
	endfunction

	function automatic resp_t rs(logic vd, logic [31:0] v, logic h, logic [2:0] s);
		resp_t r;
		r.vld = vd;
		r.val = v;
		r.hlt = h;
		r.st = s;
		return r;
	endfunction

	task automatic issue(instr_t x, logic known, resp_t typed);
		resp_t p;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= x.act;
		immediate <= x.imm;
		reg_index <= x.ri;
		in_value <= x.inv;
		do @(posedge clk); while (!in_ready);
		p = execute_instr(x);
		if (known && typed !== p) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row for action %0d: typed %h, predicted %h",
					x.act, typed, p);
		end
		expected_resp.push_back(known ? typed : p);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_resp.size() > 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return '0;
			3: return $urandom_range(65536 * 4) - 65536 * 2;
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t rand_instr();
		int          k;
		logic [3:0]  a;
		k = $urandom_range(99);
		if (k < 14) a = ACT_PUSH_IMM;
		else if (k < 22) a = ACT_PUSH_REG;
		else if (k < 32) a = ACT_POP_REG;
		else if (k < 42) a = ACT_DIV;
		else if (k < 53) a = ACT_SUB;
		else if (k < 68) a = ACT_IN;
		else if (k < 80) a = ACT_MUL;
		else if (k < 97) a = ACT_OUT;
		else a = 4'($urandom_range(9, 15));
		return mk(a, 16'($urandom), 2'($urandom), rand_val());
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > Limit) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_rready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			out_rready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		resp_t got, want;
		if (arst_n && out_rvalid && out_rready) begin
			got = {out_valid, out_value, halted, status};
			if (expected_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %h", got);
			end else begin
				want = expected_resp.pop_front();
				if (got.vld !== want.vld || got.val !== want.val || got.hlt !== want.hlt
					|| got.st !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v%0b %h h%0b s%0d, got v%0b %h h%0b s%0d",
							want.vld, want.val, want.hlt, want.st,
							got.vld, got.val, got.hlt, got.st);
				end
				if (want.vld) n_out++;
				if (want.st == ST_SAT) n_sat++;
				if (want.st == ST_DIVZ) n_divz++;
			end
		end
	end

	row_t rows [$];

	initial begin
		int     lim;
		instr_t x;
		for (int i = 0; i < Depth; i++) mdl_stack[i] = '0;
		mdl_depth = 0;
		for (int i = 0; i < 4; i++) mdl_regs[i] = '0;
		mdl_halt = 0;

		rows.push_back('{mk(ACT_OUT, 0, 0, 0), 1, rs(0, 0, 0, ST_UNDER)});
		rows.push_back('{mk(ACT_SUB, 0, 0, 0), 1, rs(0, 0, 0, ST_UNDER)});
		rows.push_back('{mk(ACT_POP_REG, 0, 3, 0), 1, rs(0, 0, 0, ST_UNDER)});
		rows.push_back('{mk(ACT_PUSH_REG, 0, 2, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_OUT, 0, 0, 0), 1, rs(1, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_PUSH_IMM, 16'h7fff, 0, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_OUT, 0, 0, 0), 1, rs(1, 32'h7fff0000, 0, ST_OK)});
		rows.push_back('{mk(ACT_PUSH_IMM, 16'h8000, 0, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_POP_REG, 0, 1, 0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_PUSH_REG, 0, 1, 0), 0, '0});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'h0), 1, rs(0, 0, 0, ST_OK)});
		rows.push_back('{mk(ACT_DIV, 0, 0, 0), 1, rs(0, 0, 0, ST_DIVZ)});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'h7fffffff), 0, '0});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'h80000000), 0, '0});
		rows.push_back('{mk(ACT_SUB, 0, 0, 0), 1, rs(0, 0, 0, ST_SAT)});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'h00008000), 0, '0});
		rows.push_back('{mk(ACT_DIV, 0, 0, 0), 1, rs(0, 0, 0, ST_SAT)});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'h7fffffff), 0, '0});
		rows.push_back('{mk(ACT_MUL, 0, 0, 0), 1, rs(0, 0, 0, ST_SAT)});
		rows.push_back('{mk(ACT_IN, 0, 0, 32'hfffe8000), 0, '0});
		rows.push_back('{mk(ACT_MUL, 0, 0, 0), 0, '0});
		rows.push_back('{mk(ACT_OUT, 0, 0, 0), 0, '0});
		rows.push_back('{mk(4'd15, 0, 0, 0), 1, rs(0, 0, 0, ST_OK)});

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) issue(rows[i].ins, rows[i].known, rows[i].rsp);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle = 69;
				recv_idle = 14;
			end else if (ph == 2) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int n = 0; n < 380; n++) begin
				if (n == 100 && ph != 1) hold_off = 300;
				if (n == 300) drain();
				if (n % 140 == 0) begin
					lim = $urandom_range(Depth + 3);
					for (int k = 0; k < lim; k++)
						issue(mk(ACT_IN, 0, 0, rand_val()), 0, '0);
					for (int k = 0; k < Depth / 2; k++)
						issue(mk(ACT_POP_REG, 0, 2'($urandom), 0), 0, '0);
				end else begin
					x = rand_instr();
					issue(x, 0, '0);
				end
			end
		end

		issue(mk(ACT_HLT, 0, 0, 0), 1, rs(0, 0, 1, ST_OK));
		issue(mk(ACT_HLT, 0, 0, 0), 1, rs(0, 0, 1, ST_IGNORED));
		issue(mk(ACT_IN, 16'hffff, 3, 32'hffffffff), 1, rs(0, 0, 1, ST_IGNORED));
		issue(mk(ACT_OUT, 0, 0, 0), 1, rs(0, 0, 1, ST_IGNORED));

		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d cycles: %0d outputs, %0d saturations, %0d zero divides",
			cycles, n_out, n_sat, n_divz);
		if (mismatches == 0 && expected_resp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches,
				expected_resp.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== stack_machine_executor_core.f =====
rtl/sme_pkg.sv
rtl/sme_ctrl.sv
rtl/sme_div.sv
rtl/sme_dp.sv
rtl/stack_machine_executor_core.sv
rtl/sme_chk.sv
test/stack_machine_executor_core_tb.sv
